[design/art_pkg.sv]
// ============================================================================
// art_pkg
// Shared constants of the adaptive retransmit timer core: event
// codes, configuration register indexes, reset values and datapath widths.
// ============================================================================
package art_pkg;

  // Event codes carried on the input tuser
  localparam logic [2:0] CMD_OPEN     = 3'd0;
  localparam logic [2:0] CMD_SEND_REQ = 3'd1;
  localparam logic [2:0] CMD_SEND_DAT = 3'd2;
  localparam logic [2:0] CMD_EXPIRE   = 3'd3;
  localparam logic [2:0] CMD_REPLY    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_INITIAL_DIVISOR = 3'd0;
  localparam logic [2:0] CFG_DIVISOR_STEP    = 3'd1;
  localparam logic [2:0] CFG_INITIAL_RTT     = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT_MULT    = 3'd3;
  localparam logic [2:0] CFG_MAX_TIMEOUT     = 3'd4;
  localparam logic [2:0] CFG_DATA_TRIES      = 3'd5;
  localparam logic [2:0] CFG_REQUEST_TRIES   = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_INITIAL_DIVISOR = 8'd8;
  localparam logic [7:0]  RST_DIVISOR_STEP    = 8'd1;
  localparam logic [15:0] RST_INITIAL_RTT     = 16'd18;
  localparam logic [3:0]  RST_TIMEOUT_MULT    = 4'd2;
  localparam logic [15:0] RST_MAX_TIMEOUT     = 16'd1000;
  localparam logic [3:0]  RST_DATA_TRIES      = 4'd6;
  localparam logic [3:0]  RST_REQUEST_TRIES   = 4'd3;

  // Timeout after reset: starting estimate times multiplier, clamped to max
  localparam int unsigned RST_PRODUCT = RST_INITIAL_RTT * RST_TIMEOUT_MULT;
  localparam logic [15:0] RST_TIMEOUT =
    (RST_PRODUCT < RST_MAX_TIMEOUT) ? RST_PRODUCT[15:0] : RST_MAX_TIMEOUT;

  // Datapath constants
  localparam logic [15:0] MIN_TIMEOUT = 16'd20;
  localparam logic [15:0] EST_MAX     = 16'hFFFF;
  localparam int unsigned ALU_W       = 33;
  localparam int unsigned PROD_W      = 20;
  localparam logic [7:0]  SENDS_MAX   = 8'd255;

endpackage

[design/adaptive_retransmit_timer_core.sv]
// ============================================================================
// adaptive_retransmit_timer_core
// Retransmission timer and round trip estimator for one connection, built
// around one shared 33-bit add/subtract unit under a small sequencer.
// ============================================================================
// Usage:
//   Input channel (s_axis_*): one transaction per event. tuser carries the
//   event code (open, send request, send data/ack, timer expired, good
//   reply) and tdata the current 32-bit tick count.
//   Output channel (m_axis_*): exactly one result transaction per event with
//   the resend and give-up flags, the retransmit timeout and the estimate.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i;
//   write only while no event is in flight.
// Sequence per event:
//   Send, expiry and unknown codes: straight to the result load.
//   Open: 4 shift-add multiply steps, clamp, result load.
//   Good reply after a clean exchange: measure, average, multiply.
//   Good reply after a resend: the 16 restoring divide
//   steps of estimate/K on the shared adder, then grow and multiply.
//   The block takes one event at a time; tready returns once the result is
//   in the output register.
// Reset: state and registers take their defaults (timeout 36 ticks).
// Stall: a finished result waits in the output register; a following result
//   waits in the sequencer until the receiver takes the first one.
module adaptive_retransmit_timer_core
  import art_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // event input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] now_ticks
  input  logic [2:0]  s_axis_tuser,   // [2:0] command
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] resend, [1] give_up,
                                      // [17:2] timeout_ticks, [33:18] rtt_estimate
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MEAS, ST_AVG, ST_DIV, ST_GROW, ST_MUL, ST_CLAMP, ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [7:0]  init_div_q, div_step_q;
  logic [15:0] init_rtt_q, max_timeout_q;
  logic [3:0]  mult_q, data_tries_q, req_tries_q;

  // connection state
  logic [15:0] rtt_est_q, retx_timeout_q;
  logic [7:0]  divisor_k_q, sends_this_q, sends_last_q;
  logic [3:0]  tries_left_q;
  logic [31:0] send_time_q;

  // sequencer work registers
  logic [31:0]       work_q;
  logic [15:0]       quo_q;
  logic [7:0]        rem_q;
  logic [PROD_W-1:0] acc_q;
  logic [3:0]        cnt_q;
  logic              reply_q, resend_q, give_up_q;

  // output register
  logic        out_valid_q, out_resend_q, out_give_up_q;
  logic [15:0] out_timeout_q, out_rtt_q;

  logic s_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_rtt_q, out_timeout_q, out_give_up_q, out_resend_q};

  // divisor selection for a good reply
  logic [7:0] load_div, k_clean, k_grow, k_dec;
  always_comb begin
    load_div = (init_div_q == 8'd0) ? 8'd1 : init_div_q;
    k_clean  = (sends_last_q == 8'd1) ? load_div : divisor_k_q;
    k_dec    = (k_clean > div_step_q) ? (k_clean - div_step_q) : 8'd1;
    k_grow   = ((sends_last_q > 8'd1) && (k_clean > 8'd1)) ? k_dec : k_clean;
    if (k_grow == 8'd0) begin
      k_grow = 8'd1;
    end
  end

  // shared add/subtract unit
  logic [ALU_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [ALU_W:0]   alu_res;
  logic [PROD_W-1:0] mul_term;

  always_comb begin
    mul_term = {{(PROD_W-16){1'b0}}, rtt_est_q} << cnt_q[1:0];
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    case (state_q)
      ST_MEAS: begin
        alu_a   = {1'b0, work_q};
        alu_b   = {1'b0, send_time_q};
        alu_sub = 1'b1;
      end
      ST_AVG: begin
        alu_a = {1'b0, work_q};
        alu_b = {{(ALU_W-16){1'b0}}, rtt_est_q};
      end
      ST_DIV: begin
        alu_a   = {{(ALU_W-9){1'b0}}, rem_q, quo_q[15]};
        alu_b   = {{(ALU_W-8){1'b0}}, divisor_k_q};
        alu_sub = 1'b1;
      end
      ST_GROW: begin
        alu_a = {{(ALU_W-16){1'b0}}, rtt_est_q};
        alu_b = {{(ALU_W-16){1'b0}}, quo_q};
      end
      ST_MUL: begin
        alu_a = {{(ALU_W-PROD_W){1'b0}}, acc_q};
        alu_b = mult_q[cnt_q[1:0]] ? {{(ALU_W-PROD_W){1'b0}}, mul_term} : '0;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {ALU_W{alu_sub}}}
            + {{ALU_W{1'b0}}, alu_sub};
  end

  // clamp the product into the timeout range; halve the sum for the average
  logic [15:0] t_max, t_fin;
  logic [31:0] avg_sum;
  always_comb begin
    t_max   = (acc_q > {{(PROD_W-16){1'b0}}, max_timeout_q}) ? max_timeout_q
                                                               : acc_q[15:0];
    t_fin   = (reply_q && (t_max < MIN_TIMEOUT)) ? MIN_TIMEOUT : t_max;
    avg_sum = alu_res[32:1];
  end

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      init_div_q     <= RST_INITIAL_DIVISOR;
      div_step_q     <= RST_DIVISOR_STEP;
      init_rtt_q     <= RST_INITIAL_RTT;
      mult_q         <= RST_TIMEOUT_MULT;
      max_timeout_q  <= RST_MAX_TIMEOUT;
      data_tries_q   <= RST_DATA_TRIES;
      req_tries_q    <= RST_REQUEST_TRIES;
      rtt_est_q      <= RST_INITIAL_RTT;
      retx_timeout_q <= RST_TIMEOUT;
      divisor_k_q    <= RST_INITIAL_DIVISOR;
      sends_this_q   <= 8'd0;
      sends_last_q   <= 8'd1;
      tries_left_q   <= 4'd0;
      send_time_q    <= 32'd0;
      work_q         <= 32'd0;
      quo_q          <= 16'd0;
      rem_q          <= 8'd0;
      acc_q          <= '0;
      cnt_q          <= 4'd0;
      reply_q        <= 1'b0;
      resend_q       <= 1'b0;
      give_up_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      out_resend_q   <= 1'b0;
      out_give_up_q  <= 1'b0;
      out_timeout_q  <= 16'd0;
      out_rtt_q      <= 16'd0;
    end else begin
      // take configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INITIAL_DIVISOR: init_div_q    <= cfg_wdata_i[7:0];
          CFG_DIVISOR_STEP:    div_step_q    <= cfg_wdata_i[7:0];
          CFG_INITIAL_RTT:     init_rtt_q    <= cfg_wdata_i;
          CFG_TIMEOUT_MULT:    mult_q        <= cfg_wdata_i[3:0];
          CFG_MAX_TIMEOUT:     max_timeout_q <= cfg_wdata_i;
          CFG_DATA_TRIES:      data_tries_q  <= cfg_wdata_i[3:0];
          CFG_REQUEST_TRIES:   req_tries_q   <= cfg_wdata_i[3:0];
          default:             ;
        endcase
      end

      // drop the result once the receiver takes it
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            resend_q  <= 1'b0;
            give_up_q <= 1'b0;
            reply_q   <= 1'b0;
            acc_q     <= '0;
            cnt_q     <= 4'd0;
            state_q   <= ST_DONE;
            case (s_axis_tuser)
              CMD_OPEN: begin
                rtt_est_q    <= init_rtt_q;
                divisor_k_q  <= load_div;
                sends_this_q <= 8'd0;
                sends_last_q <= 8'd1;
                tries_left_q <= 4'd0;
                send_time_q  <= 32'd0;
                state_q      <= ST_MUL;
              end
              CMD_SEND_REQ, CMD_SEND_DAT: begin
                tries_left_q <= (s_axis_tuser == CMD_SEND_REQ) ? req_tries_q
                                                                : data_tries_q;
                send_time_q  <= s_axis_tdata;
                sends_this_q <= 8'd1;
              end
              CMD_EXPIRE: begin
                if (tries_left_q > 4'd1) begin
                  tries_left_q <= tries_left_q - 4'd1;
                  if (sends_this_q < SENDS_MAX) begin
                    sends_this_q <= sends_this_q + 8'd1;
                  end
                  resend_q <= 1'b1;
                end else begin
                  tries_left_q <= 4'd0;
                  give_up_q    <= 1'b1;
                end
              end
              CMD_REPLY: begin
                reply_q      <= 1'b1;
                sends_last_q <= sends_this_q;
                work_q       <= s_axis_tdata;
                if (sends_this_q == 8'd1) begin
                  divisor_k_q <= k_clean;
                  state_q     <= ST_MEAS;
                end else begin
                  divisor_k_q <= k_grow;
                  quo_q       <= rtt_est_q;
                  rem_q       <= 8'd0;
                  state_q     <= ST_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MEAS: begin
          work_q  <= alu_res[31:0];
          state_q <= ST_AVG;
        end
        ST_AVG: begin
          rtt_est_q <= (|avg_sum[31:16]) ? EST_MAX : avg_sum[15:0];
          state_q   <= ST_MUL;
        end
        ST_DIV: begin
          // one restoring divide step: keep the difference when no borrow
          rem_q <= alu_res[ALU_W] ? alu_res[7:0] : {rem_q[6:0], quo_q[15]};
          quo_q <= {quo_q[14:0], alu_res[ALU_W]};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= ST_GROW;
          end
        end
        ST_GROW: begin
          rtt_est_q <= alu_res[16] ? EST_MAX : alu_res[15:0];
          state_q   <= ST_MUL;
        end
        ST_MUL: begin
          // shift-add one multiplier bit per cycle
          acc_q <= alu_res[PROD_W-1:0];
          if (cnt_q[1:0] == 2'd3) begin
            cnt_q   <= 4'd0;
            state_q <= ST_CLAMP;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_CLAMP: begin
          retx_timeout_q <= t_fin;
          state_q        <= ST_DONE;
        end
        ST_DONE: begin
          // load the result once the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q   <= 1'b1;
            out_resend_q  <= resend_q;
            out_give_up_q <= give_up_q;
            out_timeout_q <= retx_timeout_q;
            out_rtt_q     <= rtt_est_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted while sequencer busy");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divisor_k_q != 8'd0)
    else $error("growth divisor reached zero");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_resend_q && out_give_up_q))
    else $error("resend and give-up reported together");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> state_q == ST_DONE)
    else $error("pending result overwritten during stall");

endmodule
